// ===== hdl/fdc_pkg.sv =====
// Shared widths and control types for the Fresnel coefficient pipeline.
package fdc_pkg;

  localparam int COS_W   = 16;
  localparam int IDX_W   = 14;
  localparam int PROD_W  = COS_W + IDX_W;
  localparam int DEN_W   = PROD_W + 1;
  localparam int RAMP_W  = 17;
  localparam int TAMP_W  = 18;
  localparam int RFL_W   = 16;

  typedef struct packed {
    logic neg_s;
    logic neg_p;
    logic deg;
  } flags_t;

endpackage

// ===== hdl/fresnel_dielectric_coefficients_top.sv =====
// Top level of the fixed-point Fresnel dielectric coefficient pipeline.
// Throughput: one word per cycle while the pipe is not stalled; the divider bank retires
// one quotient bit per stage over its FRAC_BITS + 5 stages, the bulk of the pipe.
// Stall: the whole pipe holds while a finished word waits; bubbles are not squeezed out.
// Reset: rst_n clears every valid bit synchronously; data registers are not reset.
module fresnel_dielectric_coefficients_top #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fdc_pkg::COS_W-1:0]           in_cos_incident,
  input  logic [fdc_pkg::COS_W-1:0]           in_cos_transmitted,
  input  logic [fdc_pkg::IDX_W-1:0]           in_index_incident,
  input  logic [fdc_pkg::IDX_W-1:0]           in_index_transmitted,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fdc_pkg::RAMP_W-1:0]   out_refl_amp_s,
  output logic signed [fdc_pkg::RAMP_W-1:0]   out_refl_amp_p,
  output logic [fdc_pkg::TAMP_W-1:0]          out_trans_amp_s,
  output logic [fdc_pkg::TAMP_W-1:0]          out_trans_amp_p,
  output logic [fdc_pkg::RFL_W-1:0]           out_reflectance,
  output logic [fdc_pkg::RFL_W-1:0]           out_transmittance,
  output logic                                out_degenerate
);

  localparam int DW  = fdc_pkg::DEN_W;
  localparam int NW  = DW + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 4;
  // front: 2 stages, divider: QW + 1, back: 3 (last one is the output register)
  localparam int LAT = QW + 6;

  logic            en;
  logic [LAT-1:0]  vld_r, vld_nxt;
  logic [NW-1:0]   num_s, num_p, num_ts, num_tp;
  logic [DW-1:0]   den_s, den_p;
  logic [QW-1:0]   q_s, q_p, q_ts, q_tp;
  logic            ovf_ts, ovf_tp;
  fdc_pkg::flags_t fl_front;
  fdc_pkg::flags_t fl_r [QW+1];

  // Advance everything unless the output word is held by the consumer.
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  fdc_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk    (clk),
    .en     (en),
    .cos_i  (in_cos_incident),
    .cos_t  (in_cos_transmitted),
    .n_i    (in_index_incident),
    .n_t    (in_index_transmitted),
    .num_s  (num_s),
    .num_p  (num_p),
    .num_ts (num_ts),
    .num_tp (num_tp),
    .den_s  (den_s),
    .den_p  (den_p),
    .flags  (fl_front)
  );

  // Four dividers run side by side; rs and rp never exceed one, so their
  // overflow flags are left open.
  fdc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_s (
    .clk(clk), .en(en), .n(num_s), .d(den_s), .q(q_s), .ovf()
  );
  fdc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_p (
    .clk(clk), .en(en), .n(num_p), .d(den_p), .q(q_p), .ovf()
  );
  fdc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_ts (
    .clk(clk), .en(en), .n(num_ts), .d(den_s), .q(q_ts), .ovf(ovf_ts)
  );
  fdc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_tp (
    .clk(clk), .en(en), .n(num_tp), .d(den_p), .q(q_tp), .ovf(ovf_tp)
  );

  // Carry signs and the degenerate flag alongside the divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= fl_front;
      for (int k = 1; k <= QW; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  fdc_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk           (clk),
    .en            (en),
    .q_s           (q_s),
    .q_p           (q_p),
    .q_ts          (q_ts),
    .q_tp          (q_tp),
    .ovf_ts        (ovf_ts),
    .ovf_tp        (ovf_tp),
    .flags         (fl_r[QW]),
    .refl_amp_s    (out_refl_amp_s),
    .refl_amp_p    (out_refl_amp_p),
    .trans_amp_s   (out_trans_amp_s),
    .trans_amp_p   (out_trans_amp_p),
    .reflectance   (out_reflectance),
    .transmittance (out_transmittance),
    .degenerate    (out_degenerate)
  );

endmodule

// ===== hdl/fdc_front.sv =====
// Front end: index-times-cosine products, then numerators and denominators.
module fdc_front #(
  parameter int FRAC_BITS = 15,
  parameter int NW        = fdc_pkg::DEN_W + FRAC_BITS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [fdc_pkg::COS_W-1:0]   cos_i,
  input  logic [fdc_pkg::COS_W-1:0]   cos_t,
  input  logic [fdc_pkg::IDX_W-1:0]   n_i,
  input  logic [fdc_pkg::IDX_W-1:0]   n_t,
  output logic [NW-1:0]               num_s,
  output logic [NW-1:0]               num_p,
  output logic [NW-1:0]               num_ts,
  output logic [NW-1:0]               num_tp,
  output logic [fdc_pkg::DEN_W-1:0]   den_s,
  output logic [fdc_pkg::DEN_W-1:0]   den_p,
  output fdc_pkg::flags_t             flags
);

  localparam int PW = fdc_pkg::PROD_W;
  localparam int DW = fdc_pkg::DEN_W;

  logic [PW-1:0] a_r, b_r, c_r, d_r;
  logic [DW-1:0] dens_nxt, denp_nxt;
  logic [PW-1:0] mags_nxt, magp_nxt;
  logic [NW-1:0] twoa_nxt;
  fdc_pkg::flags_t fl_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= PW'(n_i) * PW'(cos_i);
      b_r <= PW'(n_t) * PW'(cos_t);
      c_r <= PW'(n_t) * PW'(cos_i);
      d_r <= PW'(n_i) * PW'(cos_t);
    end
  end

  always_comb begin
    dens_nxt     = DW'(a_r) + DW'(b_r);
    denp_nxt     = DW'(c_r) + DW'(d_r);
    fl_nxt.neg_s = (a_r < b_r);
    fl_nxt.neg_p = (c_r < d_r);
    fl_nxt.deg   = (dens_nxt == '0) || (denp_nxt == '0);
    mags_nxt     = fl_nxt.neg_s ? (b_r - a_r) : (a_r - b_r);
    magp_nxt     = fl_nxt.neg_p ? (d_r - c_r) : (c_r - d_r);
    twoa_nxt     = NW'(a_r) << (FRAC_BITS + 1);
  end

  // Numerator carries the half-divisor so the quotient comes out rounded.
  always_ff @(posedge clk) begin
    if (en) begin
      num_s  <= (NW'(mags_nxt) << FRAC_BITS) + NW'(dens_nxt >> 1);
      num_p  <= (NW'(magp_nxt) << FRAC_BITS) + NW'(denp_nxt >> 1);
      num_ts <= twoa_nxt + NW'(dens_nxt >> 1);
      num_tp <= twoa_nxt + NW'(denp_nxt >> 1);
      den_s  <= dens_nxt;
      den_p  <= denp_nxt;
      flags  <= fl_nxt;
    end
  end

endmodule

// ===== hdl/fdc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module fdc_div #(
  parameter int NW = 47,
  parameter int DW = 31,
  parameter int QW = 19
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf
);

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] x_r   [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [DW-1:0] hi;

  assign hi = {{(DW - (NW - QW)){1'b0}}, n[NW-1:QW]};

  // Flag quotients that would not fit in QW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      x_r[0]   <= n[QW-1:0];
      d_r[0]   <= d;
      ovf_r[0] <= (hi >= d);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial, diff;
    logic        ge;
    always_comb begin
      trial = {rem_r[k], x_r[k][QW-1]};
      diff  = trial - {1'b0, d_r[k]};
      ge    = (trial >= {1'b0, d_r[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        x_r[k+1]   <= {x_r[k][QW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign q   = x_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ===== hdl/fdc_back.sv =====
// Back end: saturation, squares, reflectance and the output word register.
module fdc_back #(
  parameter int FRAC_BITS = 15,
  parameter int QW        = FRAC_BITS + 4
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [QW-1:0]                       q_s,
  input  logic [QW-1:0]                       q_p,
  input  logic [QW-1:0]                       q_ts,
  input  logic [QW-1:0]                       q_tp,
  input  logic                                ovf_ts,
  input  logic                                ovf_tp,
  input  fdc_pkg::flags_t                     flags,
  output logic signed [fdc_pkg::RAMP_W-1:0]   refl_amp_s,
  output logic signed [fdc_pkg::RAMP_W-1:0]   refl_amp_p,
  output logic [fdc_pkg::TAMP_W-1:0]          trans_amp_s,
  output logic [fdc_pkg::TAMP_W-1:0]          trans_amp_p,
  output logic [fdc_pkg::RFL_W-1:0]           reflectance,
  output logic [fdc_pkg::RFL_W-1:0]           transmittance,
  output logic                                degenerate
);

  localparam int MW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int SW = 2 * MW;
  localparam int RW = FRAC_BITS + 2;
  localparam logic [TW-1:0] TMAX = {3'b100, {FRAC_BITS{1'b0}}};
  localparam logic [RW-1:0] ONE  = {2'b01, {FRAC_BITS{1'b0}}};

  logic [MW-1:0]   ms_r, mp_r, ms_d_r, mp_d_r;
  logic [TW-1:0]   ts_r, tp_r, ts_d_r, tp_d_r;
  logic [SW-1:0]   sqs_r, sqp_r;
  fdc_pkg::flags_t fl_c_r, fl_d_r;
  logic [SW:0]     sum;
  logic [RW-1:0]   r;
  logic [31:0]     vs, vp, vts, vtp, vr, vt;

  always_ff @(posedge clk) begin
    if (en) begin
      ms_r   <= q_s[MW-1:0];
      mp_r   <= q_p[MW-1:0];
      ts_r   <= (ovf_ts || (q_ts > QW'(TMAX))) ? TMAX : q_ts[TW-1:0];
      tp_r   <= (ovf_tp || (q_tp > QW'(TMAX))) ? TMAX : q_tp[TW-1:0];
      fl_c_r <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqs_r  <= SW'(ms_r) * SW'(ms_r);
      sqp_r  <= SW'(mp_r) * SW'(mp_r);
      ms_d_r <= ms_r;
      mp_d_r <= mp_r;
      ts_d_r <= ts_r;
      tp_d_r <= tp_r;
      fl_d_r <= fl_c_r;
    end
  end

  // Round half up, then clamp at one.
  always_comb begin
    sum = (SW+1)'(sqs_r) + (SW+1)'(sqp_r) + (SW+1)'(ONE);
    r   = RW'(sum >> (FRAC_BITS + 1));
    if (r > ONE) begin
      r = ONE;
    end
    vs  = fl_d_r.neg_s ? (32'd0 - 32'(ms_d_r)) : 32'(ms_d_r);
    vp  = fl_d_r.neg_p ? (32'd0 - 32'(mp_d_r)) : 32'(mp_d_r);
    vts = 32'(ts_d_r);
    vtp = 32'(tp_d_r);
    vr  = 32'(r);
    vt  = 32'(ONE) - 32'(r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= fl_d_r.deg;
      if (fl_d_r.deg) begin
        refl_amp_s    <= '0;
        refl_amp_p    <= '0;
        trans_amp_s   <= '0;
        trans_amp_p   <= '0;
        reflectance   <= '0;
        transmittance <= '0;
      end else begin
        refl_amp_s    <= vs[fdc_pkg::RAMP_W-1:0];
        refl_amp_p    <= vp[fdc_pkg::RAMP_W-1:0];
        trans_amp_s   <= vts[fdc_pkg::TAMP_W-1:0];
        trans_amp_p   <= vtp[fdc_pkg::TAMP_W-1:0];
        reflectance   <= vr[fdc_pkg::RFL_W-1:0];
        transmittance <= vt[fdc_pkg::RFL_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/fdc_checker.sv =====
// Port-level checks for the Fresnel pipeline and their binding to the top level.
module fdc_checker #(
  parameter int FRAC_BITS = 15
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [fdc_pkg::RAMP_W-1:0]   out_refl_amp_s,
  input logic signed [fdc_pkg::RAMP_W-1:0]   out_refl_amp_p,
  input logic [fdc_pkg::TAMP_W-1:0]          out_trans_amp_s,
  input logic [fdc_pkg::TAMP_W-1:0]          out_trans_amp_p,
  input logic [fdc_pkg::RFL_W-1:0]           out_reflectance,
  input logic [fdc_pkg::RFL_W-1:0]           out_transmittance,
  input logic                                out_degenerate
);

  localparam logic [31:0] ONE32 = 32'd1 << FRAC_BITS;
  localparam logic [fdc_pkg::RFL_W-1:0] ONE = ONE32[fdc_pkg::RFL_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reflectance)
      && $stable(out_refl_amp_s) && $stable(out_degenerate))
    else $error("output word changed while stalled");

  a_rt_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_reflectance + out_transmittance) == ONE)
    else $error("reflectance and transmittance do not sum to one");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_refl_amp_s == '0 && out_refl_amp_p == '0 && out_trans_amp_s == '0
      && out_trans_amp_p == '0 && out_reflectance == '0 && out_transmittance == '0)
    else $error("degenerate word carries nonzero results");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind fresnel_dielectric_coefficients_top fdc_checker #(.FRAC_BITS(FRAC_BITS)) u_fdc_checker (.*);
